// ===== design/disk_block_allocator_unit_assert.svh =====
// Assertion macros for the disk block allocator.
// Used by dba_ctrl and dba_datapath; expects signals named clock and reset.
`ifndef DISK_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define DISK_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DBA_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DBA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/dba_pkg.sv =====
// Shared constants, types and helpers for the disk block allocator.
// No dependencies; imported by dba_ctrl, dba_datapath and the top level.
package dba_pkg;

   localparam int NUM_BLOCKS  = 16;
   localparam int MAX_RESULTS = 16;
   localparam int BLK_W       = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int MAP_PAD     = 1 << BLK_W;
   localparam int CNT_W       = ($clog2(NUM_BLOCKS + 1) > 5) ? $clog2(NUM_BLOCKS + 1) : 5;
   localparam int TOT_W       = 6;
   localparam int OUT_BLK_W   = 4;

   localparam logic [1:0] MODE_CONTIG  = 2'd0;
   localparam logic [1:0] MODE_LINKED  = 2'd1;
   localparam logic [1:0] MODE_INDEXED = 2'd2;
   localparam logic [1:0] MODE_UNUSED  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_EMIT = 4'b0100,
      ST_FAIL = 4'b1000
   } dba_state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic emit_start;
      logic emit_take;
      logic emit_skip;
      logic fail_sel;
   } dba_cmd_type;

   typedef struct packed {
      logic req_bad;
      logic scan_hit;
      logic scan_end;
      logic cur_free;
      logic last_res;
   } dba_sts_type;

   function automatic logic [OUT_BLK_W-1:0] blk_out(input logic [BLK_W-1:0] b);
      logic [BLK_W+OUT_BLK_W-1:0] wide;
      wide = {{OUT_BLK_W{1'b0}}, b};
      return wide[OUT_BLK_W-1:0];
   endfunction

endpackage

// ===== design/dba_datapath.sv =====
// Datapath of the disk block allocator: free map, scan cursor, run counter.
// Depends on dba_pkg and disk_block_allocator_unit_assert.svh.
`include "disk_block_allocator_unit_assert.svh"

module dba_datapath
   import dba_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  dba_cmd_type          cmd,
   output dba_sts_type          sts,
   input  logic [1:0]           req_mode,
   input  logic [4:0]           req_size,
   output logic                 rsp_ok,
   output logic [OUT_BLK_W-1:0] rsp_block,
   output logic                 rsp_is_index,
   output logic                 rsp_last
);

   logic [NUM_BLOCKS-1:0] free_map_ff, free_map_in;
   logic [1:0]            mode_ff, mode_in;
   logic [CNT_W-1:0]      total_ff, total_in;
   logic [BLK_W-1:0]      cursor_ff, cursor_in;
   logic [BLK_W-1:0]      start_ff, start_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      k_ff, k_in;

   logic [TOT_W-1:0]   total_req;
   logic [MAP_PAD-1:0] map_pad;
   logic [MAP_PAD-1:0] clr_mask;
   logic [CNT_W-1:0]   count_inc;
   logic [BLK_W-1:0]   start_next;
   logic               is_contig;

   assign total_req = {1'b0, req_size} + TOT_W'(req_mode == MODE_INDEXED);
   assign map_pad   = MAP_PAD'(free_map_ff);
   assign clr_mask  = ~(MAP_PAD'(1) << cursor_ff);
   assign is_contig = (mode_ff == MODE_CONTIG);
   assign count_inc = count_ff + CNT_W'(1);

   assign sts.req_bad  = (req_size == 5'd0) || (req_mode == MODE_UNUSED) ||
                         (total_req > TOT_W'(MAX_RESULTS));
   assign sts.cur_free = map_pad[cursor_ff];
   assign sts.scan_hit = sts.cur_free && (count_inc == total_ff);
   assign sts.scan_end = (cursor_ff == BLK_W'(NUM_BLOCKS - 1));
   assign sts.last_res = ((k_ff + CNT_W'(1)) == total_ff);

   assign start_next = (sts.cur_free && (count_ff == '0)) ? cursor_ff : start_ff;

   always_comb begin
      free_map_in = free_map_ff;
      mode_in     = mode_ff;
      total_in    = total_ff;
      cursor_in   = cursor_ff;
      start_in    = start_ff;
      count_in    = count_ff;
      k_in        = k_ff;
      if (cmd.load) begin
         mode_in   = req_mode;
         total_in  = CNT_W'(total_req);
         cursor_in = '0;
         start_in  = '0;
         count_in  = '0;
      end else if (cmd.emit_start) begin
         cursor_in = is_contig ? start_next : '0;
         k_in      = '0;
      end else if (cmd.scan) begin
         start_in  = start_next;
         cursor_in = cursor_ff + BLK_W'(1);
         if (sts.cur_free) begin
            count_in = count_inc;
         end else if (is_contig) begin
            count_in = '0;
         end
      end else if (cmd.emit_take) begin
         free_map_in = free_map_ff & clr_mask[NUM_BLOCKS-1:0];
         k_in        = k_ff + CNT_W'(1);
         cursor_in   = cursor_ff + BLK_W'(1);
      end else if (cmd.emit_skip) begin
         cursor_in = cursor_ff + BLK_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_map_ff <= '1;
      end else begin
         free_map_ff <= free_map_in;
      end
      mode_ff   <= mode_in;
      total_ff  <= total_in;
      cursor_ff <= cursor_in;
      start_ff  <= start_in;
      count_ff  <= count_in;
      k_ff      <= k_in;
   end

   assign rsp_ok       = !cmd.fail_sel;
   assign rsp_block    = cmd.fail_sel ? '0 : blk_out(cursor_ff);
   assign rsp_is_index = !cmd.fail_sel && (mode_ff == MODE_INDEXED) && (k_ff == '0);
   assign rsp_last     = cmd.fail_sel || sts.last_res;

   `DBA_ASSERT_NEXT(a_take_clears_one, cmd.emit_take,
      $countones(free_map_ff) == $countones($past(free_map_ff)) - 1,
      "Delivered block was not removed from the free map.")
   `DBA_ASSERT_IMPL(a_take_in_bound, cmd.emit_take, k_ff < total_ff,
      "More blocks delivered than the request asked for.")

endmodule

// ===== design/dba_ctrl.sv =====
// Controller of the disk block allocator: request sequencing and handshakes.
// Depends on dba_pkg and disk_block_allocator_unit_assert.svh.
`include "disk_block_allocator_unit_assert.svh"

module dba_ctrl
   import dba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dba_sts_type sts,
   output dba_cmd_type cmd
);

   dba_state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_FAIL) || ((state_ff == ST_EMIT) && sts.cur_free);

   always_comb begin
      cmd.load       = (state_ff == ST_IDLE) && req_valid;
      cmd.scan       = (state_ff == ST_SCAN);
      cmd.emit_start = (state_ff == ST_SCAN) && sts.scan_hit;
      cmd.emit_take  = (state_ff == ST_EMIT) && sts.cur_free && rsp_ready;
      cmd.emit_skip  = (state_ff == ST_EMIT) && !sts.cur_free;
      cmd.fail_sel   = (state_ff == ST_FAIL);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = sts.req_bad ? ST_FAIL : ST_SCAN;
            end
         end
         ST_SCAN: begin
            priority if (sts.scan_hit) begin
               state_in = ST_EMIT;
            end else if (sts.scan_end) begin
               state_in = ST_FAIL;
            end
         end
         ST_EMIT: begin
            if (cmd.emit_take && sts.last_res) begin
               state_in = ST_IDLE;
            end
         end
         ST_FAIL: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `DBA_ASSERT_NEXT(a_last_to_idle, rsp_valid && rsp_ready && sts.last_res && !cmd.fail_sel,
      state_ff == ST_IDLE, "Controller did not return to idle after the final result.")
   `DBA_ASSERT_NEXT(a_hit_to_emit, cmd.emit_start, state_ff == ST_EMIT,
      "Scan hit did not lead to the emit state.")

endmodule

// ===== design/disk_block_allocator_unit.sv =====
// A request is taken from idle; a rejected request answers in the next cycle.
// The free map scan checks one block per cycle, over at most NUM_BLOCKS blocks, then results
// follow one per cycle while rsp_ready is high; linked and indexed order skip used blocks.
// Synchronous active-high reset marks every block free and returns the controller to idle.
module disk_block_allocator_unit
   import dba_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_mode,
   input  logic [4:0]           req_size,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_ok,
   output logic [OUT_BLK_W-1:0] rsp_block,
   output logic                 rsp_is_index,
   output logic                 rsp_last
);

   dba_cmd_type cmd;
   dba_sts_type sts;

   dba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dba_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_mode     (req_mode),
      .req_size     (req_size),
      .rsp_ok       (rsp_ok),
      .rsp_block    (rsp_block),
      .rsp_is_index (rsp_is_index),
      .rsp_last     (rsp_last)
   );

endmodule
